// File: rtl/tstc_pkg.sv
`default_nettype none

package tstc_pkg;

  localparam int COORD_BITS = 12;
  localparam int BTN_BITS   = 8;
  localparam int TIME_BITS  = 32;
  localparam int WIN_BITS   = 16;
  localparam int ARG_BITS   = 12;
  localparam int KIND_BITS  = 3;
  localparam int CODE_BITS  = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int IN_DATA_BITS  = BTN_BITS + 2 * COORD_BITS + TIME_BITS;
  localparam int OUT_FIELD_BITS = ARG_BITS + 2 * COORD_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // results waiting at the output, and per-item result count width
  localparam int QDEPTH   = 2;
  localparam int CNT_BITS = 2;

  localparam logic [WIN_BITS-1:0]   WINDOW_RST = WIN_BITS'(300);
  localparam logic [COORD_BITS-1:0] THRESH_RST = COORD_BITS'(40);

  // event kinds
  localparam logic [KIND_BITS-1:0] KIND_MOUSE_MOVE  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_MOUSE_DOWN  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_MOUSE_UP    = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_FINGER_DOWN = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_FINGER_MOVE = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_FINGER_UP   = 3'd5;

  // result codes
  localparam logic [CODE_BITS-1:0] EV_MOVE   = 3'd0;
  localparam logic [CODE_BITS-1:0] EV_DOWN   = 3'd1;
  localparam logic [CODE_BITS-1:0] EV_DBL    = 3'd2;
  localparam logic [CODE_BITS-1:0] EV_RIGHT  = 3'd3;
  localparam logic [CODE_BITS-1:0] EV_LEFT   = 3'd4;
  localparam logic [CODE_BITS-1:0] EV_SDOWN  = 3'd5;
  localparam logic [CODE_BITS-1:0] EV_SUP    = 3'd6;
  localparam logic [CODE_BITS-1:0] EV_UP     = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DTAP   = 2'd2;

  typedef struct packed {
    logic [WIN_BITS-1:0]   window;
    logic [COORD_BITS-1:0] thresh;
    logic                  dtap_en;
  } cfg_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  code;
    logic [ARG_BITS-1:0]   arg;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/touch_swipe_tap_classifier.sv
`default_nettype none

// Pointer gesture classifier. Each input word is one mouse or finger event
// (kind in in_tuser; button, x, y and a wrapping millisecond time in in_tdata)
// and gives one result word, or two for an up that completes a slide: the
// slide word with tlast low, then the up word with tlast high. Kinds 6 and 7
// give nothing. An event is taken every cycle while the output queue has room:
// it is held in an input register, is classified by a single level of
// subtract/compare logic against the stored press, and lands in a two-word
// output queue. Throughput is one event per cycle while the sink keeps up; an
// up with a slide puts out two words, the queue holds the extra one, and the
// input stalls when the next slide comes before the queue has drained. An
// accepted event passes the input register and then the output queue before
// its first result word is valid. Registers are written through cfg_*
// (0 window in ms, 1 slide threshold, 2 finger double tap enable), always
// ready, and should be written only while the block is idle.
module touch_swipe_tap_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // button[7:0], pos_x[19:8], pos_y[31:20], time_ms[63:32]
  input  wire logic [tstc_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // kind[2:0]
  input  wire logic [tstc_pkg::KIND_BITS-1:0]      in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // event_arg[11:0], out_x[23:12], out_y[35:24], zero pad
  output logic [tstc_pkg::OUT_DATA_BITS-1:0]       out_tdata,
  // event_code[2:0]
  output logic [tstc_pkg::CODE_BITS-1:0]           out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tstc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tstc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tstc_pkg::*;

  cfg_t                cfg;
  logic [CNT_BITS-1:0] room;
  logic                push;
  logic [CNT_BITS-1:0] push_n;
  result_t             res0, res1;
  result_t             out_word;

  assign cfg_ready = 1'b1;

  tstc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tstc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_button (in_tdata[BTN_BITS-1:0]),
    .in_x      (in_tdata[BTN_BITS +: COORD_BITS]),
    .in_y      (in_tdata[BTN_BITS+COORD_BITS +: COORD_BITS]),
    .in_time   (in_tdata[BTN_BITS+2*COORD_BITS +: TIME_BITS]),
    .room      (room),
    .push      (push),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1)
  );

  tstc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = OUT_DATA_BITS'({out_word.y, out_word.x, out_word.arg});
  assign out_tuser = out_word.code;
  assign out_tlast = out_word.last;

endmodule

`default_nettype wire

// File: rtl/tstc_cfg.sv
`default_nettype none

module tstc_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [tstc_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  wire logic [tstc_pkg::CFG_DATA_BITS-1:0] wr_data,
  output tstc_pkg::cfg_t                          cfg
);
  import tstc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_WINDOW: cfg_nxt.window  = wr_data[WIN_BITS-1:0];
        CFG_THRESH: cfg_nxt.thresh  = wr_data[COORD_BITS-1:0];
        CFG_DTAP:   cfg_nxt.dtap_en = wr_data[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window  <= WINDOW_RST;
      cfg_r.thresh  <= THRESH_RST;
      cfg_r.dtap_en <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/tstc_classify.sv
`default_nettype none

module tstc_classify (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  tstc_pkg::cfg_t                        cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tstc_pkg::KIND_BITS-1:0]   in_kind,
  input  wire logic [tstc_pkg::BTN_BITS-1:0]    in_button,
  input  wire logic [tstc_pkg::COORD_BITS-1:0]  in_x,
  input  wire logic [tstc_pkg::COORD_BITS-1:0]  in_y,
  input  wire logic [tstc_pkg::TIME_BITS-1:0]   in_time,
  input  wire logic [tstc_pkg::CNT_BITS-1:0]    room,
  output logic                                 push,
  output logic [tstc_pkg::CNT_BITS-1:0]         push_n,
  output tstc_pkg::result_t                     res0,
  output tstc_pkg::result_t                     res1
);
  import tstc_pkg::*;

  // input register
  logic                  vld_r;
  logic [KIND_BITS-1:0]  kind_r;
  logic [BTN_BITS-1:0]   btn_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;
  logic [TIME_BITS-1:0]  t_r;

  // last press
  logic [TIME_BITS-1:0]  ptime_r, ptime_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;

  logic                  consume;
  logic                  finger;
  logic [ARG_BITS-1:0]   btn;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  in_win;
  logic                  x_gt, y_gt;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  x_win, y_hit;
  logic [CNT_BITS-1:0]   n;

  always_comb begin
    finger  = (kind_r >= KIND_FINGER_DOWN);
    btn     = finger ? ARG_BITS'(1) : ARG_BITS'(btn_r);
    elapsed = t_r - ptime_r;
    in_win  = (elapsed <= TIME_BITS'(cfg.window));
    x_gt    = (x_r > px_r);
    y_gt    = (y_r > py_r);
    dx      = x_gt ? (x_r - px_r) : (px_r - x_r);
    dy      = y_gt ? (y_r - py_r) : (py_r - y_r);
    x_win   = (dx >= cfg.thresh) && (dx > dy);
    y_hit   = (dy >= cfg.thresh);
  end

  always_comb begin
    n         = '0;
    res0.code = EV_MOVE;
    res0.arg  = btn;
    res0.x    = x_r;
    res0.y    = y_r;
    res0.last = 1'b1;
    res1      = res0;
    res1.code = EV_UP;
    ptime_nxt = ptime_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    unique case (kind_r) inside
      KIND_MOUSE_MOVE, KIND_FINGER_MOVE: begin
        n = CNT_BITS'(1);
      end
      KIND_MOUSE_DOWN, KIND_FINGER_DOWN: begin
        n = CNT_BITS'(1);
        if (in_win && (!finger || cfg.dtap_en)) begin
          res0.code = EV_DBL;
          ptime_nxt = '0;
        end else begin
          res0.code = EV_DOWN;
          ptime_nxt = t_r;
          px_nxt    = x_r;
          py_nxt    = y_r;
        end
      end
      KIND_MOUSE_UP, KIND_FINGER_UP: begin
        if (in_win && (x_win || y_hit)) begin
          // slide word first, then the up word
          n         = CNT_BITS'(2);
          res0.last = 1'b0;
          if (x_win) begin
            res0.code = x_gt ? EV_RIGHT : EV_LEFT;
            res0.arg  = ARG_BITS'(dx);
          end else begin
            res0.code = y_gt ? EV_SDOWN : EV_SUP;
            res0.arg  = ARG_BITS'(dy);
          end
        end else begin
          n         = CNT_BITS'(1);
          res0.code = EV_UP;
        end
      end
      default: n = '0;
    endcase
  end

  assign consume  = vld_r && (n <= room);
  assign in_ready = !vld_r || consume;
  assign push     = consume && (n != '0);
  assign push_n   = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      ptime_r <= '0;
      px_r    <= '0;
      py_r    <= '0;
    end else begin
      if (in_ready) begin
        vld_r <= in_valid;
      end
      if (consume) begin
        ptime_r <= ptime_nxt;
        px_r    <= px_nxt;
        py_r    <= py_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r <= in_kind;
      btn_r  <= in_button;
      x_r    <= in_x;
      y_r    <= in_y;
      t_r    <= in_time;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tstc_outq.sv
`default_nettype none

module tstc_outq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [tstc_pkg::CNT_BITS-1:0] push_n,
  input  tstc_pkg::result_t                  res0,
  input  tstc_pkg::result_t                  res1,
  output logic [tstc_pkg::CNT_BITS-1:0]      room,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tstc_pkg::result_t                  out_word
);
  import tstc_pkg::*;

  result_t             q0_r, q0_nxt;
  result_t             q1_r, q1_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] cnt_ap;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = CNT_BITS'(QDEPTH) - cnt_r + CNT_BITS'(pop);
  assign out_word  = q0_r;

  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    cnt_ap = cnt_r - CNT_BITS'(pop);
    if (pop) begin
      q0_nxt = q1_r;
    end
    cnt_nxt = cnt_ap;
    if (push) begin
      cnt_nxt = cnt_ap + push_n;
      case (cnt_ap)
        CNT_BITS'(0): begin
          q0_nxt = res0;
          if (push_n == CNT_BITS'(2)) begin
            q1_nxt = res1;
          end
        end
        CNT_BITS'(1): q1_nxt = res0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

`default_nettype wire

// File: verif/touch_swipe_tap_classifier_tb.sv
`default_nettype none

module touch_swipe_tap_classifier_tb;
  import tstc_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;

  class gesture_scoreboard;
    logic [WIN_BITS-1:0]   window;
    logic [COORD_BITS-1:0] thresh;
    logic                  dtap_en;
    logic [TIME_BITS-1:0]  press_time;
    logic [COORD_BITS-1:0] press_x;
    logic [COORD_BITS-1:0] press_y;
    result_t               gesture_q[$];
    int                    errors;

    function new();
      window     = WINDOW_RST;
      thresh     = THRESH_RST;
      dtap_en    = 1'b0;
      press_time = '0;
      press_x    = '0;
      press_y    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return gesture_q.size();
    endfunction

    task report(input string msg);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_WINDOW: window  = value[WIN_BITS-1:0];
        CFG_THRESH: thresh  = value[COORD_BITS-1:0];
        CFG_DTAP:   dtap_en = value[0];
        default: ;
      endcase
    endfunction

    function void queue_result(input logic [CODE_BITS-1:0] code,
                               input logic [ARG_BITS-1:0] arg,
                               input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y,
                               input logic fin);
      result_t r;
      r.code = code;
      r.arg  = arg;
      r.x    = x;
      r.y    = y;
      r.last = fin;
      gesture_q.push_back(r);
    endfunction

    // classify one accepted pointer word and queue the words it must produce
    function void note_event(input logic [KIND_BITS-1:0] kind,
                             input logic [BTN_BITS-1:0] button,
                             input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y,
                             input logic [TIME_BITS-1:0] t);
      logic                  finger;
      logic [ARG_BITS-1:0]   btn;
      logic [TIME_BITS-1:0]  elapsed;
      logic                  in_win;
      logic [COORD_BITS-1:0] dx;
      logic [COORD_BITS-1:0] dy;
      finger  = (kind == KIND_FINGER_DOWN) || (kind == KIND_FINGER_MOVE) ||
                (kind == KIND_FINGER_UP);
      btn     = finger ? ARG_BITS'(1) : ARG_BITS'(button);
      elapsed = t - press_time;
      in_win  = elapsed <= TIME_BITS'(window);
      dx      = (x > press_x) ? x - press_x : press_x - x;
      dy      = (y > press_y) ? y - press_y : press_y - y;
      case (kind)
        KIND_MOUSE_MOVE, KIND_FINGER_MOVE: queue_result(EV_MOVE, btn, x, y, 1'b1);
        KIND_MOUSE_DOWN, KIND_FINGER_DOWN: begin
          if (in_win && (!finger || dtap_en)) begin
            queue_result(EV_DBL, btn, x, y, 1'b1);
            press_time = '0;
          end else begin
            queue_result(EV_DOWN, btn, x, y, 1'b1);
            press_time = t;
            press_x    = x;
            press_y    = y;
          end
        end
        KIND_MOUSE_UP, KIND_FINGER_UP: begin
          if (in_win) begin
            if (dx >= thresh && dx > dy)
              queue_result((x > press_x) ? EV_RIGHT : EV_LEFT, dx, x, y, 1'b0);
            else if (dy >= thresh)
              queue_result((y > press_y) ? EV_SDOWN : EV_SUP, dy, x, y, 1'b0);
          end
          queue_result(EV_UP, btn, x, y, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task check_word(input result_t got);
      result_t want;
      if (gesture_q.size() == 0) begin
        report($sformatf("unexpected word code %0d arg %0d x %0d y %0d last %0b",
                         got.code, got.arg, got.x, got.y, got.last));
      end else begin
        want = gesture_q.pop_front();
        if (got !== want)
          report($sformatf("code %0d/%0d arg %0d/%0d x %0d/%0d y %0d/%0d last %0b/%0b",
                           got.code, want.code, got.arg, want.arg, got.x, want.x,
                           got.y, want.y, got.last, want.last));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [KIND_BITS-1:0]     in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [CODE_BITS-1:0]     out_tuser;
  logic                     out_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  gesture_scoreboard sb = new();
  result_t           seen_word;
  int                cycle_count = 0;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                sent_events = 0;
  int                cur_window = 300;
  int                cur_thresh = 40;
  logic [TIME_BITS-1:0] now_ms = '0;

  touch_swipe_tap_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && in_tvalid && in_tready)
      sb.note_event(in_tuser, in_tdata[7:0], in_tdata[19:8], in_tdata[31:20],
                    in_tdata[63:32]);
    if (rst_n && out_tvalid && out_tready) begin
      seen_word.code = out_tuser;
      seen_word.arg  = out_tdata[11:0];
      seen_word.x    = out_tdata[23:12];
      seen_word.y    = out_tdata[35:24];
      seen_word.last = out_tlast;
      sb.check_word(seen_word);
    end
  end

  task automatic send_event(input logic [KIND_BITS-1:0] kind,
                            input logic [BTN_BITS-1:0] button,
                            input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y,
                            input logic [TIME_BITS-1:0] t);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {t, y, x, button};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    if (kind != KIND_UNUSED_LO && kind != KIND_UNUSED_HI) sent_events++;
  endtask

  // stop sending and wait until every queued word has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic wait_cfg_word();
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic set_config(input int window, input int thresh, input int dtap);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data  <= CFG_DATA_BITS'(window);
    wait_cfg_word();
    cfg_index <= CFG_THRESH;
    cfg_data  <= CFG_DATA_BITS'(thresh);
    wait_cfg_word();
    cfg_index <= CFG_DTAP;
    cfg_data  <= CFG_DATA_BITS'(dtap);
    wait_cfg_word();
    cfg_valid  <= 1'b0;
    cur_window = window;
    cur_thresh = thresh;
  endtask

  // move a coordinate by mag in a random direction, staying on the screen
  function automatic logic [COORD_BITS-1:0] shift_coord(input logic [COORD_BITS-1:0] base,
                                                        input int mag);
    int v;
    v = $urandom_range(1) ? int'(base) + mag : int'(base) - mag;
    if (v > COORD_MAX) v = int'(base) - mag;
    else if (v < 0) v = int'(base) + mag;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < 0) v = 0;
    return COORD_BITS'(v);
  endfunction

  // time since the press: mostly inside the window, often on its edge
  function automatic logic [TIME_BITS-1:0] pick_elapsed();
    case ($urandom_range(9))
      0: return TIME_BITS'(cur_window);
      1: return TIME_BITS'(cur_window + 1);
      2: return '0;
      8, 9: return TIME_BITS'(cur_window + $urandom_range(1, 1000));
      default: return TIME_BITS'($urandom_range(cur_window));
    endcase
  endfunction

  task automatic run_gestures(input int n_events);
    int                    first;
    int                    mode;
    int                    mx;
    int                    my;
    int                    near;
    logic                  finger;
    logic [BTN_BITS-1:0]   btn;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [KIND_BITS-1:0]  down_kind;
    logic [KIND_BITS-1:0]  up_kind;
    logic [TIME_BITS-1:0]  t_press;
    logic [TIME_BITS-1:0]  t_rel;
    first = sent_events;
    while (sent_events - first < n_events) begin
      finger    = 1'($urandom_range(1));
      btn       = BTN_BITS'($urandom_range(255));
      px        = COORD_BITS'($urandom_range(COORD_MAX));
      py        = COORD_BITS'($urandom_range(COORD_MAX));
      down_kind = finger ? KIND_FINGER_DOWN : KIND_MOUSE_DOWN;
      up_kind   = finger ? KIND_FINGER_UP : KIND_MOUSE_UP;
      if ($urandom_range(49) == 0) now_ms = $urandom();
      else now_ms += $urandom_range(2 * cur_window + 20);
      mode = $urandom_range(99);
      if (mode < 15) begin
        send_event(KIND_BITS'($urandom_range(7)), btn,
                   COORD_BITS'($urandom_range(COORD_MAX)),
                   COORD_BITS'($urandom_range(COORD_MAX)),
                   (mode < 5) ? $urandom() : now_ms);
      end else if (mode < 40) begin
        // press, maybe release, press again
        t_press = now_ms;
        send_event(down_kind, btn, px, py, t_press);
        if ($urandom_range(1))
          send_event(up_kind, btn, px, py, t_press + $urandom_range(cur_window));
        now_ms = t_press + pick_elapsed();
        send_event(down_kind, btn, shift_coord(px, $urandom_range(8)), py, now_ms);
      end else begin
        // press, up to three moves, release with a travel mostly around the threshold
        near = cur_thresh + $urandom_range(6) - 3;
        if (near < 0) near = 0;
        case ($urandom_range(3))
          0: begin mx = near; my = $urandom_range(near); end
          1: begin my = near; mx = $urandom_range(near); end
          2: begin mx = near; my = near; end
          default: begin mx = $urandom_range(COORD_MAX); my = $urandom_range(COORD_MAX); end
        endcase
        t_press = now_ms;
        t_rel   = pick_elapsed();
        send_event(down_kind, btn, px, py, t_press);
        repeat ($urandom_range(3))
          send_event(finger ? KIND_FINGER_MOVE : KIND_MOUSE_MOVE, btn,
                     shift_coord(px, $urandom_range(mx)), shift_coord(py, $urandom_range(my)),
                     t_press + $urandom_range(t_rel));
        now_ms = t_press + t_rel;
        send_event(up_kind, btn, shift_coord(px, mx), shift_coord(py, my), now_ms);
      end
    end
  endtask

  task automatic run_phase(input int window, input int thresh, input int dtap,
                           input int gap, input int stall, input int n_events);
    set_config(window, thresh, dtap);
    gap_pct   = gap;
    stall_pct = stall;
    run_gestures(n_events / 2);
    drain_results();
    run_gestures(n_events - n_events / 2);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: window 300, threshold 40, finger double tap off
    send_event(KIND_MOUSE_MOVE, 8'hFF, 12'd4095, 12'd0, 32'd1000);
    send_event(KIND_FINGER_MOVE, 8'h00, 12'd0, 12'd4095, 32'd1001);
    send_event(KIND_MOUSE_DOWN, 8'h00, 12'd12, 12'd34, 32'd100);      // near press time zero
    send_event(KIND_MOUSE_DOWN, 8'd3, 12'd100, 12'd100, 32'd5000);
    send_event(KIND_MOUSE_UP, 8'd3, 12'd200, 12'd110, 32'd5100);      // right
    send_event(KIND_FINGER_DOWN, 8'hAA, 12'd200, 12'd200, 32'd6000);
    send_event(KIND_FINGER_UP, 8'hAA, 12'd150, 12'd205, 32'd6200);    // left
    send_event(KIND_MOUSE_DOWN, 8'd1, 12'd500, 12'd500, 32'd7000);
    send_event(KIND_MOUSE_UP, 8'd1, 12'd510, 12'd600, 32'd7300);      // down, on window edge
    send_event(KIND_MOUSE_DOWN, 8'd2, 12'd500, 12'd500, 32'd8000);
    send_event(KIND_MOUSE_UP, 8'd2, 12'd460, 12'd460, 32'd8100);      // equal travel goes to y
    send_event(KIND_MOUSE_DOWN, 8'd4, 12'd0, 12'd0, 32'd9000);
    send_event(KIND_MOUSE_UP, 8'd4, 12'd4095, 12'd0, 32'd9301);       // just past the window
    send_event(KIND_FINGER_DOWN, 8'd1, 12'd10, 12'd10, 32'd10000);
    send_event(KIND_FINGER_DOWN, 8'd1, 12'd10, 12'd10, 32'd10050);    // double tap disabled
    send_event(KIND_UNUSED_LO, 8'hFF, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_event(KIND_UNUSED_HI, 8'hFF, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_event(KIND_MOUSE_DOWN, 8'h80, 12'd300, 12'd300, 32'hFFFF_FF00);
    send_event(KIND_MOUSE_UP, 8'h80, 12'd300, 12'd339, 32'h0000_0010); // time wraps
    send_event(KIND_MOUSE_DOWN, 8'h80, 12'd300, 12'd300, 32'h0000_0020);
    send_event(KIND_MOUSE_UP, 8'h01, 12'd340, 12'd300, 32'h0000_0040); // travel equals threshold

    run_phase(65535, 4095, 1, 0, 0, 200);
    run_phase(0, 0, 0, 50, 0, 200);
    run_phase(300, 40, 1, 0, 50, 200);
    run_phase($urandom_range(2000), $urandom_range(300), $urandom_range(1), 12, 12, 200);
    run_phase($urandom_range(2000), $urandom_range(300), $urandom_range(1), 0, 0, 200);
    run_phase($urandom_range(2000), $urandom_range(300), $urandom_range(1), 50, 0, 200);
    run_phase($urandom_range(2000), $urandom_range(300), $urandom_range(1), 0, 50, 200);
    run_phase($urandom_range(65535), $urandom_range(4095), $urandom_range(1), 12, 12, 200);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never came out", sb.pending()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
